// File: hw/rtl/vne_pkg.sv
`default_nettype none
package vne_pkg;

  localparam int unsigned MAX_VERTS = 4096;
  localparam int unsigned VIDX_W    = 12;
  localparam int unsigned COORD_W   = 24;
  localparam int unsigned NORM_W    = 16;
  localparam int unsigned ACC_W     = 60;
  localparam int unsigned VCNT_W    = 13;
  localparam int unsigned CFG_W     = 24;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned EDGE_W    = COORD_W + 1;
  localparam int unsigned CROSS_W   = 2 * EDGE_W + 2;
  localparam int unsigned MUL_W     = 33;
  localparam int unsigned PROD_W    = 2 * MUL_W;
  localparam int unsigned QUO_W     = NORM_W - 1;

  localparam logic [QUO_W-1:0] NORM_ONE = QUO_W'(1) << (NORM_W - 2);
  localparam logic signed [ACC_W:0] ACC_LIMIT = (ACC_W+1)'((64'd1 << 59) - 64'd1);

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_TRI  = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXTRUDE_RADIUS = 1'd1;

  typedef struct packed {
    logic [1:0]                kind;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic [VIDX_W-1:0]         vert_a;
    logic [VIDX_W-1:0]         vert_b;
    logic [VIDX_W-1:0]         vert_c;
  } vne_in_t;

  typedef struct packed {
    logic [VIDX_W-1:0]         vertex_index;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [NORM_W-1:0]  norm_x;
    logic signed [NORM_W-1:0]  norm_y;
    logic signed [NORM_W-1:0]  norm_z;
  } vne_out_t;

endpackage
`default_nettype wire

// File: hw/rtl/vne_ram.sv
`default_nettype none
module vne_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hw/rtl/vertex_normal_extrude.sv
`default_nettype none
// Area-weighted vertex normals with outward extrusion. start is taken while busy is low.
// A load keeps busy high after acceptance, and a triangle until it has done its three
// position reads, six cross-product multiplies and three accumulator read-modify-writes
// through one memory port. A triangle with a corner at or above vertex_count and an
// unknown kind are dropped at acceptance and leave busy low. A readout of a zero
// accumulator goes straight to the push; otherwise it runs a magnitude pre-shift of up to
// 29 steps, squares on the shared multiplier, a 32-step square root and three divisions.
// A readout's result appears on out_item for exactly one cycle with out_valid high, the
// cycle that busy drops; it cannot be held off.
// Stored entries need a load before use; there is no clearing pass after reset.
module vertex_normal_extrude (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire vne_pkg::vne_in_t               in_item,
  output logic                                out_valid,
  output vne_pkg::vne_out_t                   out_item,
  input  wire logic                           cfg_we,
  input  wire logic [vne_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [vne_pkg::CFG_W-1:0]      cfg_wdata
);

  localparam int unsigned CW = vne_pkg::COORD_W;
  localparam int unsigned AW = vne_pkg::ACC_W;
  localparam int unsigned EW = vne_pkg::EDGE_W;
  localparam int unsigned XW = vne_pkg::CROSS_W;
  localparam int unsigned MW = vne_pkg::MUL_W;
  localparam int unsigned QW = vne_pkg::QUO_W;
  localparam int unsigned VW = vne_pkg::VIDX_W;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_TRI_RD, S_EDGE, S_CROSS, S_ACC_RD, S_ACC_WR,
    S_RD_RD, S_RD_CAP, S_NORM, S_SQ, S_SQRT, S_DIV_INIT, S_DIV, S_PUSH, S_OUT
  } state_t;

  state_t                     state_r;
  vne_pkg::vne_in_t           item_r;
  logic [4:0]                 step_r;
  logic [1:0]                 k_r;
  logic [vne_pkg::VCNT_W-1:0] vcount_r;
  logic [CW-1:0]              radius_r;
  logic                       out_valid_r;
  vne_pkg::vne_out_t          out_r;

  logic [3*CW-1:0]       vp_r [3];
  logic signed [EW-1:0]  e1_r [3];
  logic signed [EW-1:0]  e2_r [3];
  logic signed [XW-1:0]  n_r  [3];
  logic [AW-1:0]         m_r  [3];
  logic                  sgn_r [3];
  logic [QW-1:0]         nmag_r [3];
  logic                  nneg_r [3];
  logic signed [CW-1:0]  res_r [3];
  logic [63:0]           x_r;
  logic [63:0]           r_r;
  logic [31:0]           len_r;
  logic [32:0]           rem_r;
  logic [QW-1:0]         numlo_r;
  logic [QW-1:0]         q_r;
  logic signed [2*MW-1:0] prod_r;

  // memories
  logic              pos_we, acc_we;
  logic [VW-1:0]     pos_raddr, acc_raddr, acc_waddr;
  logic [3*CW-1:0]   pos_rdata;
  logic [3*AW-1:0]   acc_wdata, acc_rdata, acc_new;

  vne_ram #(.WIDTH(3*CW), .DEPTH(vne_pkg::MAX_VERTS)) u_pos_ram (
    .clk(clk), .we(pos_we), .waddr(item_r.vert_a),
    .wdata({item_r.coord_z, item_r.coord_y, item_r.coord_x}),
    .raddr(pos_raddr), .rdata(pos_rdata)
  );

  vne_ram #(.WIDTH(3*AW), .DEPTH(vne_pkg::MAX_VERTS)) u_acc_ram (
    .clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
    .raddr(acc_raddr), .rdata(acc_rdata)
  );

  function automatic logic [VW-1:0] corner(input vne_pkg::vne_in_t it, input logic [1:0] i);
    case (i)
      2'd0:    corner = it.vert_a;
      2'd1:    corner = it.vert_b;
      default: corner = it.vert_c;
    endcase
  endfunction

  always_comb begin
    pos_we    = (state_r == S_LOAD);
    pos_raddr = (state_r == S_TRI_RD) ? corner(item_r, step_r[1:0]) : item_r.vert_a;
    acc_raddr = (state_r == S_ACC_RD) ? corner(item_r, k_r) : item_r.vert_a;
    acc_waddr = (state_r == S_ACC_WR) ? corner(item_r, k_r) : item_r.vert_a;
    acc_we    = (state_r == S_LOAD) || (state_r == S_ACC_WR);
    acc_wdata = (state_r == S_ACC_WR) ? acc_new : '0;
  end

  // saturating accumulate of the face normal
  logic signed [AW:0] acc_sum [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc_sum[k] = $signed({acc_rdata[AW*k+AW-1], acc_rdata[AW*k +: AW]})
                 + $signed({{(AW+1-XW){n_r[k][XW-1]}}, n_r[k]});
      if (acc_sum[k] > vne_pkg::ACC_LIMIT) begin
        acc_new[AW*k +: AW] = vne_pkg::ACC_LIMIT[AW-1:0];
      end else if (acc_sum[k] < -vne_pkg::ACC_LIMIT) begin
        acc_new[AW*k +: AW] = AW'(-vne_pkg::ACC_LIMIT);
      end else begin
        acc_new[AW*k +: AW] = acc_sum[k][AW-1:0];
      end
    end
  end

  // shared multiplier operand select
  logic signed [MW-1:0] mul_a, mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_CROSS: begin
        case (step_r[2:0])
          3'd0: begin mul_a = MW'(e1_r[1]); mul_b = MW'(e2_r[2]); end
          3'd1: begin mul_a = MW'(e1_r[2]); mul_b = MW'(e2_r[1]); end
          3'd2: begin mul_a = MW'(e1_r[2]); mul_b = MW'(e2_r[0]); end
          3'd3: begin mul_a = MW'(e1_r[0]); mul_b = MW'(e2_r[2]); end
          3'd4: begin mul_a = MW'(e1_r[0]); mul_b = MW'(e2_r[1]); end
          3'd5: begin mul_a = MW'(e1_r[1]); mul_b = MW'(e2_r[0]); end
          default: ;
        endcase
      end
      S_SQ: begin
        if (step_r[1:0] != 2'd3) begin
          mul_a = $signed({3'b0, m_r[step_r[1:0]][29:0]});
          mul_b = mul_a;
        end
      end
      S_PUSH: begin
        if (step_r[1:0] != 2'd3) begin
          mul_a = $signed({(MW-QW)'(0), nmag_r[step_r[1:0]]});
          mul_b = $signed({(MW-CW)'(0), radius_r});
        end
      end
      default: ;
    endcase
  end

  // square root, division and push steps
  logic [63:0]  sq_bit, sq_trial;
  logic         sq_ge;
  logic [32:0]  dv_t;
  logic         dv_ge;
  logic [QW-1:0] dv_q;
  logic [45:0]  dv_num;
  logic [1:0]   pidx;
  logic [1:0]   cidx;
  logic [25:0]  p_off;
  logic signed [CW+2:0] p_sum;
  logic signed [CW-1:0] p_sat;
  logic signed [CW+2:0] sat_hi, sat_lo;

  always_comb begin
    sq_bit   = 64'd1 << {5'd31 - step_r, 1'b0};
    sq_trial = r_r + sq_bit;
    sq_ge    = (x_r >= sq_trial);
    dv_t     = {rem_r[31:0], numlo_r[QW-1]};
    dv_ge    = (dv_t >= {1'b0, len_r});
    dv_q     = {q_r[QW-2:0], dv_ge};
    dv_num   = {2'b0, m_r[k_r][29:0], 14'b0} + {15'b0, r_r[31:1]};
    pidx     = step_r[1:0] - 2'd1;
    cidx     = 2'((step_r[2:0] - 3'd1) >> 1);
    p_off    = 26'(({1'b0, prod_r[38:0]} + 40'd8192) >> 14);
    p_sum    = $signed({{3{vp_r[0][CW*pidx+CW-1]}}, vp_r[0][CW*pidx +: CW]})
             + (nneg_r[pidx] ? -$signed({1'b0, p_off}) : $signed({1'b0, p_off}));
    sat_hi   = (CW+3)'((1 << (CW-1)) - 1);
    sat_lo   = -sat_hi - (CW+3)'(1);
    if (p_sum > sat_hi) begin
      p_sat = sat_hi[CW-1:0];
    end else if (p_sum < sat_lo) begin
      p_sat = sat_lo[CW-1:0];
    end else begin
      p_sat = p_sum[CW-1:0];
    end
  end

  logic signed [XW-1:0] cross_term;
  assign cross_term = $signed(prod_r[XW-1:0]);

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      vcount_r    <= '0;
      radius_r    <= '0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_addr)
          vne_pkg::REG_VERTEX_COUNT:   vcount_r <= cfg_wdata[vne_pkg::VCNT_W-1:0];
          vne_pkg::REG_EXTRUDE_RADIUS: radius_r <= cfg_wdata[CW-1:0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          step_r <= '0;
          k_r    <= '0;
          if (start) begin
            item_r <= in_item;
            case (in_item.kind)
              vne_pkg::KIND_LOAD: state_r <= S_LOAD;
              vne_pkg::KIND_TRI: begin
                if ({1'b0, in_item.vert_a} < vcount_r && {1'b0, in_item.vert_b} < vcount_r &&
                    {1'b0, in_item.vert_c} < vcount_r) begin
                  state_r <= S_TRI_RD;
                end
              end
              vne_pkg::KIND_READ: state_r <= S_RD_RD;
              default: ;
            endcase
          end
        end
        S_LOAD: state_r <= S_IDLE;
        S_TRI_RD: begin
          if (step_r != 5'd0) begin
            vp_r[step_r[1:0] - 2'd1] <= pos_rdata;
          end
          step_r <= step_r + 5'd1;
          if (step_r == 5'd3) begin
            state_r <= S_EDGE;
          end
        end
        S_EDGE: begin
          for (int k = 0; k < 3; k++) begin
            e1_r[k] <= $signed({vp_r[1][CW*k+CW-1], vp_r[1][CW*k +: CW]})
                     - $signed({vp_r[0][CW*k+CW-1], vp_r[0][CW*k +: CW]});
            e2_r[k] <= $signed({vp_r[2][CW*k+CW-1], vp_r[2][CW*k +: CW]})
                     - $signed({vp_r[0][CW*k+CW-1], vp_r[0][CW*k +: CW]});
            n_r[k]  <= '0;
          end
          step_r  <= '0;
          state_r <= S_CROSS;
        end
        S_CROSS: begin
          // odd steps add the first product of each component, even steps subtract
          if (step_r != 5'd0) begin
            if (step_r[0]) begin
              n_r[cidx] <= n_r[cidx] + cross_term;
            end else begin
              n_r[cidx] <= n_r[cidx] - cross_term;
            end
          end
          step_r <= step_r + 5'd1;
          if (step_r == 5'd6) begin
            state_r <= S_ACC_RD;
          end
        end
        S_ACC_RD: state_r <= S_ACC_WR;
        S_ACC_WR: begin
          k_r <= k_r + 2'd1;
          state_r <= (k_r == 2'd2) ? S_IDLE : S_ACC_RD;
        end
        S_RD_RD: state_r <= S_RD_CAP;
        S_RD_CAP: begin
          vp_r[0] <= pos_rdata;
          for (int k = 0; k < 3; k++) begin
            sgn_r[k] <= acc_rdata[AW*k+AW-1];
            m_r[k]   <= acc_rdata[AW*k+AW-1] ? -acc_rdata[AW*k +: AW] : acc_rdata[AW*k +: AW];
          end
          step_r <= '0;
          if (acc_rdata == '0) begin
            nmag_r[0] <= '0;
            nmag_r[1] <= vne_pkg::NORM_ONE;
            nmag_r[2] <= '0;
            for (int k = 0; k < 3; k++) begin
              nneg_r[k] <= 1'b0;
            end
            state_r <= S_PUSH;
          end else begin
            state_r <= S_NORM;
          end
        end
        S_NORM: begin
          if (m_r[0][AW-1:30] != '0 || m_r[1][AW-1:30] != '0 || m_r[2][AW-1:30] != '0) begin
            for (int k = 0; k < 3; k++) begin
              m_r[k] <= m_r[k] >> 1;
            end
          end else begin
            x_r     <= '0;
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          if (step_r != 5'd0) begin
            x_r <= x_r + prod_r[63:0];
          end
          if (step_r == 5'd3) begin
            r_r     <= '0;
            step_r  <= '0;
            state_r <= S_SQRT;
          end else begin
            step_r <= step_r + 5'd1;
          end
        end
        S_SQRT: begin
          if (sq_ge) begin
            x_r <= x_r - sq_trial;
            r_r <= (r_r >> 1) + sq_bit;
          end else begin
            r_r <= r_r >> 1;
          end
          step_r <= step_r + 5'd1;
          if (step_r == 5'd31) begin
            k_r     <= '0;
            state_r <= S_DIV_INIT;
          end
        end
        S_DIV_INIT: begin
          len_r   <= r_r[31:0];
          rem_r   <= {2'b0, dv_num[45:QW]};
          numlo_r <= dv_num[QW-1:0];
          q_r     <= '0;
          step_r  <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r   <= dv_ge ? dv_t - {1'b0, len_r} : dv_t;
          q_r     <= dv_q;
          numlo_r <= numlo_r << 1;
          if (step_r == 5'(QW - 1)) begin
            nmag_r[k_r] <= (dv_q > vne_pkg::NORM_ONE) ? vne_pkg::NORM_ONE : dv_q;
            nneg_r[k_r] <= sgn_r[k_r];
            k_r         <= k_r + 2'd1;
            step_r      <= '0;
            state_r     <= (k_r == 2'd2) ? S_PUSH : S_DIV_INIT;
          end else begin
            step_r <= step_r + 5'd1;
          end
        end
        S_PUSH: begin
          if (step_r != 5'd0) begin
            res_r[pidx] <= p_sat;
          end
          step_r <= step_r + 5'd1;
          if (step_r == 5'd3) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          out_valid_r         <= 1'b1;
          out_r.vertex_index  <= item_r.vert_a;
          out_r.pos_x         <= res_r[0];
          out_r.pos_y         <= res_r[1];
          out_r.pos_z         <= res_r[2];
          out_r.norm_x        <= nneg_r[0] ? -$signed({1'b0, nmag_r[0]}) : $signed({1'b0, nmag_r[0]});
          out_r.norm_y        <= nneg_r[1] ? -$signed({1'b0, nmag_r[1]}) : $signed({1'b0, nmag_r[1]});
          out_r.norm_z        <= nneg_r[2] ? -$signed({1'b0, nmag_r[2]}) : $signed({1'b0, nmag_r[2]});
          state_r             <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
`default_nettype wire

// File: hw/rtl/vne_checker.sv
`default_nettype none
module vne_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          start,
  input wire logic                          busy,
  input wire vne_pkg::vne_in_t              in_item,
  input wire logic                          out_valid,
  input wire vne_pkg::vne_out_t             out_item
);

  // an accepted load or readout raises busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.kind == vne_pkg::KIND_LOAD ||
                        in_item.kind == vne_pkg::KIND_READ)) |=> busy)
    else $error("accepted transaction did not raise busy");

  // a result shows up as busy drops, never mid-transaction
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy))) else $error("result outside end of transaction");

  a_out_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_item.norm_x) <= 16'sd16384 &&
                   $signed(out_item.norm_x) >= -16'sd16384 &&
                   $signed(out_item.norm_y) <= 16'sd16384 &&
                   $signed(out_item.norm_y) >= -16'sd16384 &&
                   $signed(out_item.norm_z) <= 16'sd16384 &&
                   $signed(out_item.norm_z) >= -16'sd16384))
    else $error("normal component beyond unit range");

endmodule

bind vertex_normal_extrude vne_checker u_vne_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
  .out_valid(out_valid), .out_item(out_item)
);
`default_nettype wire
